// ===== hw/rtl/grmw_pkg.sv =====
`timescale 1ns / 1ps

package grmw_pkg;

	localparam int CELL_SHIFT_DEF = 6;
	localparam int MAP_DIM_DEF    = 64;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int POS_W    = 24;
	localparam int DIST_W   = 23;
	localparam int CELL_W   = 6;
	localparam int MAPREG_W = 7;
	localparam int STEPS_W  = 14;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// root unit: radicand is the sum of two 25-bit squares
	localparam int SQ_IN_W  = 50;
	localparam int SQ_OUT_W = 25;
	localparam int SQ_ITERS = 25;
	localparam int SQ_CNT_W = 5;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_CAST  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_HIT   = 2'd0,
		STATUS_OUT   = 2'd1,
		STATUS_LIMIT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_MAP_WIDTH  = 3'd0,
		REG_MAP_HEIGHT = 3'd1,
		REG_PLAYER_X   = 3'd2,
		REG_PLAYER_Y   = 3'd3,
		REG_MAX_STEPS  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_EVAL,
		ST_SQ_X,
		ST_SQ_Y,
		ST_LOAD,
		ST_ROOT,
		ST_DONE
	} state_t;

	localparam logic [MAPREG_W-1:0] MAP_WIDTH_RST  = 7'd64;
	localparam logic [MAPREG_W-1:0] MAP_HEIGHT_RST = 7'd64;
	localparam logic [STEPS_W-1:0]  MAX_STEPS_RST  = 14'd4096;

	localparam pos_t POS_MAX = 24'sh7FFFFF;
	localparam pos_t POS_MIN = 24'sh800000;
	localparam dist_t DIST_MAX = 23'h7FFFFF;

endpackage

// ===== hw/rtl/grmw_req_if.sv =====
`timescale 1ns / 1ps

interface grmw_req_if;
	logic                  valid;
	logic                  ready;
	logic                  command;
	grmw_pkg::cell_t       cell_x;
	grmw_pkg::cell_t       cell_y;
	logic                  cell_is_wall;
	grmw_pkg::pos_t        start_x;
	grmw_pkg::pos_t        start_y;
	grmw_pkg::pos_t        step_x;
	grmw_pkg::pos_t        step_y;
	logic                  axis;

	modport source (
		output valid, command, cell_x, cell_y, cell_is_wall,
		output start_x, start_y, step_x, step_y, axis,
		input  ready
	);
	modport sink (
		input  valid, command, cell_x, cell_y, cell_is_wall,
		input  start_x, start_y, step_x, step_y, axis,
		output ready
	);
endinterface

// ===== hw/rtl/grmw_rsp_if.sv =====
`timescale 1ns / 1ps

interface grmw_rsp_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	grmw_pkg::pos_t        hit_x;
	grmw_pkg::pos_t        hit_y;
	grmw_pkg::dist_t       distance;
	logic                  axis_out;

	modport source (
		output valid, status, hit_x, hit_y, distance, axis_out,
		input  ready
	);
	modport sink (
		input  valid, status, hit_x, hit_y, distance, axis_out,
		output ready
	);
endinterface

// ===== hw/rtl/grmw_ram.sv =====
`timescale 1ns / 1ps

module grmw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/grmw_isqrt.sv =====
`timescale 1ns / 1ps

// Floor square root, one result bit per cycle (digit-by-digit, base 4).
module grmw_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [grmw_pkg::SQ_IN_W-1:0]  radicand,
	output logic                          done,
	output logic [grmw_pkg::SQ_OUT_W-1:0] root
);

	localparam int W = grmw_pkg::SQ_IN_W;

	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  root_q;
	logic [W-1:0]                  bit_q;
	logic [grmw_pkg::SQ_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [W:0] trial;
	logic       fits;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign fits  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= grmw_pkg::SQ_CNT_W'(grmw_pkg::SQ_ITERS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= W'(1) << (2 * (grmw_pkg::SQ_ITERS - 1));
		end else if (busy_q) begin
			if (fits) begin
				rem_q  <= rem_q - trial[W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[grmw_pkg::SQ_OUT_W-1:0];

endmodule

// ===== hw/rtl/grid_ray_march_wall_hit_unit.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Beat contents
// req     | in  | command, cell_x, cell_y, cell_is_wall, start_x/y, step_x/y, axis
// rsp     | out | status, hit_x, hit_y, distance, axis_out (one beat per cast)
// apb     | in  | map_width, map_height, player_x, player_y, max_steps at 4*index
//
// A write beat is taken in its accept cycle. A cast takes its accept cycle, then CHECK and EVAL
// per cell checked (only CHECK when off the map; the map RAM read is registered), then on a hit
// the SQ_X and SQ_Y multiply states, LOAD and ROOT (25 root iterations, then done), then DONE
// for the result. After reset a clear pass writes MAP_DIM*MAP_DIM cells
// with req.ready low; APB writes are taken meanwhile. A result waits in
// the output register while the next beat is taken; a second one holds until it frees.
module grid_ray_march_wall_hit_unit #(
	parameter int CELL_SHIFT = grmw_pkg::CELL_SHIFT_DEF,
	parameter int MAP_DIM    = grmw_pkg::MAP_DIM_DEF,
	parameter int FRAC_BITS  = grmw_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	grmw_req_if.sink                      req,
	grmw_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [grmw_pkg::PADDR_W-1:0]  paddr,
	input  logic [grmw_pkg::PDATA_W-1:0]  pwdata,
	output logic [grmw_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAP_DIM);
	localparam int PW    = grmw_pkg::POS_W;
	localparam int SH    = FRAC_BITS + CELL_SHIFT;

	// ---------------- configuration ----------------
	logic [grmw_pkg::MAPREG_W-1:0] map_width_q;
	logic [grmw_pkg::MAPREG_W-1:0] map_height_q;
	grmw_pkg::pos_t                player_x_q;
	grmw_pkg::pos_t                player_y_q;
	logic [grmw_pkg::STEPS_W-1:0]  max_steps_q;
	grmw_pkg::reg_idx_t            reg_idx;

	assign reg_idx = grmw_pkg::reg_idx_t'(paddr[4:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= grmw_pkg::MAP_WIDTH_RST;
			map_height_q <= grmw_pkg::MAP_HEIGHT_RST;
			player_x_q   <= '0;
			player_y_q   <= '0;
			max_steps_q  <= grmw_pkg::MAX_STEPS_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				grmw_pkg::REG_MAP_WIDTH:  map_width_q  <= pwdata[grmw_pkg::MAPREG_W-1:0];
				grmw_pkg::REG_MAP_HEIGHT: map_height_q <= pwdata[grmw_pkg::MAPREG_W-1:0];
				grmw_pkg::REG_PLAYER_X:   player_x_q   <= pwdata[PW-1:0];
				grmw_pkg::REG_PLAYER_Y:   player_y_q   <= pwdata[PW-1:0];
				grmw_pkg::REG_MAX_STEPS:  max_steps_q  <= pwdata[grmw_pkg::STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			grmw_pkg::REG_MAP_WIDTH:  prdata = grmw_pkg::PDATA_W'(map_width_q);
			grmw_pkg::REG_MAP_HEIGHT: prdata = grmw_pkg::PDATA_W'(map_height_q);
			grmw_pkg::REG_PLAYER_X:   prdata = grmw_pkg::PDATA_W'(player_x_q);
			grmw_pkg::REG_PLAYER_Y:   prdata = grmw_pkg::PDATA_W'(player_y_q);
			grmw_pkg::REG_MAX_STEPS:  prdata = grmw_pkg::PDATA_W'(max_steps_q);
			default:                  prdata = '0;
		endcase
	end

	// ---------------- march datapath ----------------
	grmw_pkg::state_t  state_q, state_d;
	logic [AW-1:0]     clr_q;
	grmw_pkg::pos_t    px_q, py_q, sx_q, sy_q;
	logic [grmw_pkg::STEPS_W-1:0] steps_q;
	logic              axis_q;
	grmw_pkg::status_t status_q;
	logic [grmw_pkg::SQ_IN_W-1:0] acc_q;
	logic [grmw_pkg::SQ_IN_W-1:0] prod_q;

	logic [PW-1:0] w_lim, h_lim, cx_full, cy_full;
	logic          outside;
	logic [AW-1:0] cell_addr, wr_addr;
	logic          wr_in_map;
	logic [PW:0]   nx, ny;
	logic          ovf_x, ovf_y;
	grmw_pkg::pos_t nx_sat, ny_sat;

	// effective map size is min(register, MAP_DIM)
	assign w_lim = (PW'(map_width_q) < PW'(MAP_DIM)) ? PW'(map_width_q) : PW'(MAP_DIM);
	assign h_lim = (PW'(map_height_q) < PW'(MAP_DIM)) ? PW'(map_height_q) : PW'(MAP_DIM);
	assign cx_full = PW'(px_q) >> SH;
	assign cy_full = PW'(py_q) >> SH;
	assign outside = px_q[PW-1] || py_q[PW-1] || (cx_full >= w_lim) || (cy_full >= h_lim);
	assign cell_addr = AW'(cy_full[IW-1:0]) * AW'(MAP_DIM) + AW'(cx_full[IW-1:0]);

	assign wr_in_map = (9'(req.cell_x) < 9'(MAP_DIM)) && (9'(req.cell_y) < 9'(MAP_DIM));
	assign wr_addr   = AW'(IW'(req.cell_y)) * AW'(MAP_DIM) + AW'(IW'(req.cell_x));

	assign nx     = {px_q[PW-1], px_q} + {sx_q[PW-1], sx_q};
	assign ny     = {py_q[PW-1], py_q} + {sy_q[PW-1], sy_q};
	assign ovf_x  = nx[PW] ^ nx[PW-1];
	assign ovf_y  = ny[PW] ^ ny[PW-1];
	assign nx_sat = ovf_x ? (nx[PW] ? grmw_pkg::POS_MIN : grmw_pkg::POS_MAX) : nx[PW-1:0];
	assign ny_sat = ovf_y ? (ny[PW] ? grmw_pkg::POS_MIN : grmw_pkg::POS_MAX) : ny[PW-1:0];

	// shared multiplier: squares |dx| then |dy|
	logic [PW:0] dx, dy, adx, ady, mul_op;
	logic [grmw_pkg::SQ_IN_W-1:0] prod;

	assign dx     = {px_q[PW-1], px_q} - {player_x_q[PW-1], player_x_q};
	assign dy     = {py_q[PW-1], py_q} - {player_y_q[PW-1], player_y_q};
	assign adx    = dx[PW] ? -dx : dx;
	assign ady    = dy[PW] ? -dy : dy;
	assign mul_op = (state_q == grmw_pkg::ST_SQ_X) ? adx : ady;
	assign prod   = mul_op * mul_op;

	// ---------------- map RAM and root unit ----------------
	logic          ram_we, ram_wdata, ram_rdata;
	logic [AW-1:0] ram_waddr;
	logic          sq_start, sq_done;
	logic [grmw_pkg::SQ_OUT_W-1:0] sq_root;

	grmw_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cell_addr),
		.rdata (ram_rdata)
	);

	grmw_isqrt u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q + prod_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	// ---------------- sequencer ----------------
	logic req_ready, load_out, out_valid_q;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		req_ready = 1'b0;
		sq_start  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			grmw_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == AW'(DEPTH - 1)) state_d = grmw_pkg::ST_IDLE;
			end
			grmw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					if (req.command == grmw_pkg::CMD_CAST) begin
						state_d = grmw_pkg::ST_CHECK;
					end else if (wr_in_map) begin
						ram_we    = 1'b1;
						ram_waddr = wr_addr;
						ram_wdata = req.cell_is_wall;
					end
				end
			end
			grmw_pkg::ST_CHECK: begin
				state_d = outside ? grmw_pkg::ST_DONE : grmw_pkg::ST_EVAL;
			end
			grmw_pkg::ST_EVAL: begin
				if (ram_rdata) begin
					state_d = grmw_pkg::ST_SQ_X;
				end else if (steps_q >= max_steps_q || ovf_x || ovf_y) begin
					state_d = grmw_pkg::ST_DONE;
				end else begin
					state_d = grmw_pkg::ST_CHECK;
				end
			end
			grmw_pkg::ST_SQ_X: state_d = grmw_pkg::ST_SQ_Y;
			grmw_pkg::ST_SQ_Y: state_d = grmw_pkg::ST_LOAD;
			grmw_pkg::ST_LOAD: begin
				sq_start = 1'b1;
				state_d  = grmw_pkg::ST_ROOT;
			end
			grmw_pkg::ST_ROOT: begin
				if (sq_done) state_d = grmw_pkg::ST_DONE;
			end
			grmw_pkg::ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = grmw_pkg::ST_IDLE;
				end
			end
			default: state_d = grmw_pkg::ST_IDLE;
		endcase
	end

	assign req.ready = req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grmw_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == grmw_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			grmw_pkg::ST_IDLE: begin
				if (req.valid && req.command == grmw_pkg::CMD_CAST) begin
					px_q    <= req.start_x;
					py_q    <= req.start_y;
					sx_q    <= req.step_x;
					sy_q    <= req.step_y;
					axis_q  <= req.axis;
					steps_q <= '0;
				end
			end
			grmw_pkg::ST_CHECK: begin
				if (outside) status_q <= grmw_pkg::STATUS_OUT;
			end
			grmw_pkg::ST_EVAL: begin
				if (ram_rdata) begin
					status_q <= grmw_pkg::STATUS_HIT;
				end else if (steps_q >= max_steps_q) begin
					status_q <= grmw_pkg::STATUS_LIMIT;
				end else begin
					px_q    <= nx_sat;
					py_q    <= ny_sat;
					steps_q <= steps_q + 1'b1;
					if (ovf_x || ovf_y) status_q <= grmw_pkg::STATUS_OUT;
				end
			end
			grmw_pkg::ST_SQ_X: acc_q  <= prod;
			grmw_pkg::ST_SQ_Y: prod_q <= prod;
			default: ;
		endcase
	end

	// ---------------- result register ----------------
	logic [1:0]      res_status_q;
	grmw_pkg::pos_t  res_x_q, res_y_q;
	grmw_pkg::dist_t res_dist_q;
	logic            res_axis_q;
	grmw_pkg::dist_t dist_sat;

	assign dist_sat = (sq_root[grmw_pkg::SQ_OUT_W-1:grmw_pkg::DIST_W] != '0)
		? grmw_pkg::DIST_MAX : sq_root[grmw_pkg::DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_status_q <= status_q;
			res_x_q      <= px_q;
			res_y_q      <= py_q;
			res_dist_q   <= (status_q == grmw_pkg::STATUS_HIT) ? dist_sat : '0;
			res_axis_q   <= axis_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = res_status_q;
	assign rsp.hit_x    = res_x_q;
	assign rsp.hit_y    = res_y_q;
	assign rsp.distance = res_dist_q;
	assign rsp.axis_out = res_axis_q;

	// ---------------- assertions ----------------
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == grmw_pkg::ST_DONE && out_valid_q && !rsp.ready)
		|=> state_q == grmw_pkg::ST_DONE)
		else $error("finished cast left DONE while result register full");

	a_dist_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != grmw_pkg::STATUS_HIT) |-> rsp.distance == '0)
		else $error("nonzero distance on a miss");

	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == grmw_pkg::ST_EVAL) |-> steps_q <= max_steps_q)
		else $error("march step count passed the limit");

	a_root_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == grmw_pkg::ST_ROOT)
		else $error("root unit finished outside the root wait");

endmodule
